[hdl/mvi_pkg.sv]
// Shared types and codes for the multi-version index block.
// Holds the request, response and table-entry structs; no dependencies.
`default_nettype none

package mvi_pkg;

    // Request kinds
    typedef enum logic [1:0] {
        REQ_INSERT = 2'd0,
        REQ_COMMIT = 2'd1,
        REQ_LOOKUP = 2'd2,
        REQ_CAS    = 2'd3
    } req_kind_t;

    // Response status codes
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_MISMATCH  = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

    typedef struct packed {
        req_kind_t   req_type;
        logic [63:0] key_high;
        logic [63:0] key_low;
        logic [47:0] body_offset;
        logic [31:0] body_length;
        logic [7:0]  layer;
        logic        tombstone;
        logic [31:0] snapshot;
        logic [31:0] expected_version;
    } req_t;

    typedef struct packed {
        status_t     status;
        logic [31:0] hit_version;
        logic [47:0] hit_offset;
        logic [31:0] hit_length;
        logic [7:0]  hit_layer;
        logic        hit_tombstone;
        logic [31:0] current_sequence;
    } rsp_t;

    // One stored version of a record
    typedef struct packed {
        logic [63:0] id_high;
        logic [63:0] id_low;
        logic [47:0] offset;
        logic [31:0] length;
        logic [31:0] version;
        logic [7:0]  layer;
        logic        tomb;
    } entry_t;

endpackage

`default_nettype wire

[hdl/mvi_store.sv]
// Entry table of the multi-version index: one write port, one registered read port.
// Depends on mvi_pkg for the entry layout.
`default_nettype none

module mvi_store #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  wire logic            clk,
    input  wire logic            wr_en,
    input  wire logic [AW-1:0]   wr_addr,
    input  wire mvi_pkg::entry_t wr_data,
    input  wire logic            rd_en,
    input  wire logic [AW-1:0]   rd_addr,
    output mvi_pkg::entry_t      rd_data
);

    mvi_pkg::entry_t mem [DEPTH];

    // Write the appended entry
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Register the scanned entry
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

[hdl/mvcc_version_index.sv]
// Multi-version index: versioned entries keyed by 128-bit ids, with snapshot lookup and CAS check.
// Insert and commit answer with done in the cycle after the request is taken, leaving the block idle.
// Lookup and CAS scan the N stored entries one per cycle through a single compare unit, then pass
// through the drain and report states (straight to report when N = 0); busy stays high meanwhile.
// New requests are taken only while idle; the entry-table read port sets the scan rate.
// Reset clears the entry count and commit sequence; table contents are not cleared.
`default_nettype none

module mvcc_version_index #(
    parameter int TABLE_DEPTH = 1024
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    output logic               busy,
    input  wire mvi_pkg::req_t req,
    output logic               done,
    output mvi_pkg::rsp_t      rsp
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SCAN   = 4'b0010,
        S_DRAIN  = 4'b0100,
        S_REPORT = 4'b1000
    } state_t;

    state_t          state_reg, state_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [31:0]     seq_reg, seq_next;
    logic [AW-1:0]   idx_reg, idx_next;
    logic            rd_vld_reg, rd_vld_next;
    logic            found_reg, found_next;
    mvi_pkg::entry_t best_reg, best_next;
    mvi_pkg::req_kind_t kind_reg, kind_next;
    logic [63:0]     key_high_reg, key_high_next;
    logic [63:0]     key_low_reg, key_low_next;
    logic [31:0]     limit_reg, limit_next;
    logic [31:0]     expect_reg, expect_next;
    logic            done_reg, done_next;
    mvi_pkg::rsp_t   rsp_reg, rsp_next;

    logic            accept;
    logic            full;
    logic            wr_en;
    mvi_pkg::entry_t wr_data;
    mvi_pkg::entry_t rd_data;
    logic            take;
    logic            last_idx;
    logic [31:0]     cur_version;

    assign accept   = start && !busy;
    assign full     = (count_reg == CW'(TABLE_DEPTH));
    assign last_idx = ((CW'(idx_reg) + CW'(1)) == count_reg);

    // Append a new entry on insert when there is room
    assign wr_en = accept && (req.req_type == mvi_pkg::REQ_INSERT) && !full;
    always_comb
    begin
        wr_data.id_high = req.key_high;
        wr_data.id_low  = req.key_low;
        wr_data.offset  = req.body_offset;
        wr_data.length  = req.body_length;
        wr_data.version = seq_reg + 32'd1;
        wr_data.layer   = req.layer;
        wr_data.tomb    = req.tombstone;
    end

    mvi_store #(
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[AW-1:0]),
        .wr_data (wr_data),
        .rd_en   (state_reg == S_SCAN),
        .rd_addr (idx_reg),
        .rd_data (rd_data)
    );

    // Shared compare unit: same id, visible version, not older than the best so far
    assign take = rd_vld_reg
                  && (rd_data.id_high == key_high_reg)
                  && (rd_data.id_low == key_low_reg)
                  && (rd_data.version <= limit_reg)
                  && (!found_reg || (rd_data.version >= best_reg.version));

    assign cur_version = found_reg ? best_reg.version : 32'd0;

    // Sequencer and result formation
    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        seq_next      = seq_reg;
        idx_next      = idx_reg;
        rd_vld_next   = (state_reg == S_SCAN);
        found_next    = found_reg;
        best_next     = best_reg;
        kind_next     = kind_reg;
        key_high_next = key_high_reg;
        key_low_next  = key_low_reg;
        limit_next    = limit_reg;
        expect_next   = expect_reg;
        done_next     = 1'b0;
        rsp_next      = rsp_reg;

        // Keep the best candidate seen by the scan
        if (take)
        begin
            found_next = 1'b1;
            best_next  = rd_data;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    kind_next     = req.req_type;
                    key_high_next = req.key_high;
                    key_low_next  = req.key_low;
                    expect_next   = req.expected_version;
                    found_next    = 1'b0;
                    idx_next      = '0;
                    limit_next    = (req.req_type == mvi_pkg::REQ_LOOKUP) ? req.snapshot
                                                                          : seq_reg;
                    rsp_next      = '0;
                    unique case (req.req_type)
                        mvi_pkg::REQ_INSERT:
                        begin
                            done_next = 1'b1;
                            if (full)
                            begin
                                rsp_next.status = mvi_pkg::ST_FULL;
                            end
                            else
                            begin
                                count_next = count_reg + CW'(1);
                            end
                            rsp_next.current_sequence = seq_reg;
                        end
                        mvi_pkg::REQ_COMMIT:
                        begin
                            done_next                 = 1'b1;
                            seq_next                  = seq_reg + 32'd1;
                            rsp_next.current_sequence = seq_reg + 32'd1;
                        end
                        mvi_pkg::REQ_LOOKUP,
                        mvi_pkg::REQ_CAS:
                        begin
                            state_next = (count_reg == '0) ? S_REPORT : S_SCAN;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                idx_next = idx_reg + AW'(1);
                if (last_idx)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_REPORT;
            end
            S_REPORT:
            begin
                state_next = S_IDLE;
                done_next  = 1'b1;
                rsp_next   = '0;
                rsp_next.current_sequence = seq_reg;
                if (found_reg)
                begin
                    rsp_next.hit_version   = best_reg.version;
                    rsp_next.hit_offset    = best_reg.offset;
                    rsp_next.hit_length    = best_reg.length;
                    rsp_next.hit_layer     = best_reg.layer;
                    rsp_next.hit_tombstone = best_reg.tomb;
                end
                if (kind_reg == mvi_pkg::REQ_LOOKUP)
                begin
                    rsp_next.status = (!found_reg || best_reg.tomb) ? mvi_pkg::ST_NOT_FOUND
                                                                    : mvi_pkg::ST_OK;
                end
                else
                begin
                    rsp_next.status = (cur_version == expect_reg) ? mvi_pkg::ST_OK
                                                                  : mvi_pkg::ST_MISMATCH;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            seq_reg    <= '0;
            idx_reg    <= '0;
            rd_vld_reg <= 1'b0;
            found_reg  <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            seq_reg    <= seq_next;
            idx_reg    <= idx_next;
            rd_vld_reg <= rd_vld_next;
            found_reg  <= found_next;
            done_reg   <= done_next;
        end
    end

    // Request and result payload
    always_ff @(posedge clk)
    begin
        best_reg     <= best_next;
        kind_reg     <= kind_next;
        key_high_reg <= key_high_next;
        key_low_reg  <= key_low_next;
        limit_reg    <= limit_next;
        expect_reg   <= expect_next;
        rsp_reg      <= rsp_next;
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;
    assign rsp  = rsp_reg;

`ifndef NO_ASSERTIONS
    // A result follows only a report step or a taken insert or commit
    a_done_source: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == S_REPORT
                       || (accept && (req.req_type == mvi_pkg::REQ_INSERT
                                      || req.req_type == mvi_pkg::REQ_COMMIT))))
        else $error("result strobe without a finished request");

    // Entry count stays within the table
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(TABLE_DEPTH))
        else $error("entry count beyond table depth");

    // Scan index stays below the entry count
    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (CW'(idx_reg) < count_reg))
        else $error("scan index past stored entries");

    // Commit sequence moves only on a taken commit
    a_seq_commit: assert property (@(posedge clk) disable iff (!rst_n)
        (seq_reg != $past(seq_reg)) |->
            $past(accept && (req.req_type == mvi_pkg::REQ_COMMIT)))
        else $error("commit sequence changed without a commit");
`endif

endmodule

`default_nettype wire
